### sv/bst_insert_delete_node_pool_unit_defines.svh
// Assertion macros shared by the pool unit
`ifndef BST_INSERT_DELETE_NODE_POOL_UNIT_DEFINES_SVH
`define BST_INSERT_DELETE_NODE_POOL_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define BSTP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define BSTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bstp_pkg.sv
// ----------------------------------------------------------------------------
// bstp_pkg
// Shared types and codes for the node pool search tree unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bstp_pkg;
  localparam logic       FUNC_INSERT = 1'b0;
  localparam logic       FUNC_DELETE = 1'b1;
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [55:0] nick_hi;
    logic [55:0] nick_lo;
  } bstp_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] out_key;
    logic [55:0] out_nick_hi;
    logic [55:0] out_nick_lo;
  } bstp_rsp_t;
endpackage

### sv/bstp_if.sv
// ----------------------------------------------------------------------------
// bstp_req_if / bstp_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface bstp_req_if import bstp_pkg::*; ();
  logic      valid;
  logic      ready;
  bstp_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bstp_rsp_if import bstp_pkg::*; ();
  logic      valid;
  logic      ready;
  bstp_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/bstp_ram.sv
// ----------------------------------------------------------------------------
// bstp_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/bst_insert_delete_node_pool_unit.sv
// ----------------------------------------------------------------------------
// bst_insert_delete_node_pool_unit
// Binary search tree over a fixed pool of node slots with a threaded free list.
// ----------------------------------------------------------------------------
// One request at a time. A request walks the tree one node at a time (address,
// then registered read of the node RAM); a two-child delete then walks down to
// the successor. Search and successor walk together visit at most NODES nodes.
// After reset a pass that clears the left links and threads the free list
// through every slot runs before the first request is accepted.
// The result sits in an output register; the next request is taken while it
// waits.
`timescale 1ns / 1ps
`include "bst_insert_delete_node_pool_unit_defines.svh"
module bst_insert_delete_node_pool_unit import bstp_pkg::*; #(
  parameter int NODES = 16
) (
  input  logic clk,
  input  logic rst_n,
  bstp_req_if.sink   in_ch,
  bstp_rsp_if.source out_ch
);
  localparam int AW = $clog2(NODES);
  localparam int LW = AW + 1;
  localparam int DW = 32 + 56 + 56 + 2 * LW;
  localparam logic [LW-1:0] NIL = LW'(NODES);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SCMP  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FIX   = 4'd7;
  localparam logic [3:0] S_LINK  = 4'd8;
  localparam logic [3:0] S_LRD   = 4'd9;
  localparam logic [3:0] S_REL   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  typedef struct packed {
    logic [31:0]   key;
    logic [55:0]   hi;
    logic [55:0]   lo;
    logic [LW-1:0] left;
    logic [LW-1:0] right;
  } node_t;

  logic [3:0]    state_r, state_nxt;
  logic [AW:0]   init_r, init_nxt;
  bstp_req_t     req_r, req_nxt;
  logic [LW-1:0] root_r, root_nxt, free_r, free_nxt;
  logic [LW-1:0] cur_r, cur_nxt, par_r, par_nxt;
  logic          side_r, side_nxt;
  logic [LW-1:0] fnd_r, fnd_nxt, sp_r, sp_nxt;
  logic          ss_r, ss_nxt;
  logic [AW:0]   steps_r, steps_nxt;
  node_t         fnode_r, fnode_nxt;
  node_t         snode_r, snode_nxt;
  logic [LW-1:0] plink_r, plink_nxt;  // parent, side, value to patch
  logic          pside_r, pside_nxt;
  logic [LW-1:0] pval_r, pval_nxt;
  logic [LW-1:0] freed_r, freed_nxt;
  bstp_rsp_t     rsp_r, rsp_nxt;
  bstp_rsp_t     orsp_r, orsp_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  node_t         wnode, rnode;
  logic [DW-1:0] rword;

  assign rnode = node_t'(rword);

  bstp_ram #(.WIDTH(DW), .DEPTH(NODES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(DW'(wnode)),
    .raddr(raddr), .rdata(rword)
  );

  function automatic logic [LW-1:0] lnk(input logic [LW-1:0] v);
    return (v < NIL) ? v : NIL;
  endfunction

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = orsp_r;

  always_comb begin
    state_nxt = state_r; init_nxt = init_r; req_nxt = req_r;
    root_nxt = root_r; free_nxt = free_r; cur_nxt = cur_r; par_nxt = par_r;
    side_nxt = side_r; fnd_nxt = fnd_r; sp_nxt = sp_r; ss_nxt = ss_r;
    steps_nxt = steps_r; fnode_nxt = fnode_r; snode_nxt = snode_r;
    plink_nxt = plink_r; pside_nxt = pside_r; pval_nxt = pval_r;
    freed_nxt = freed_r; rsp_nxt = rsp_r; orsp_nxt = orsp_r; ov_nxt = ov_r;
    we = 1'b0; waddr = '0; wnode = '0; raddr = cur_r[AW-1:0];
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_INIT: begin
        we = 1'b1;
        waddr = init_r[AW-1:0];
        wnode.left = NIL;
        wnode.right = (init_r == '0) ? NIL : LW'(init_r - 1'b1);
        init_nxt = init_r + 1'b1;
        if (init_r == (AW+1)'(NODES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt = in_ch.data;
          cur_nxt = lnk(root_r);
          par_nxt = NIL; side_nxt = 1'b0; steps_nxt = '0;
          rsp_nxt = '0;
          if (in_ch.data.func == FUNC_INSERT && lnk(free_r) == NIL) begin
            rsp_nxt.status = ST_FULL;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (cur_r == NIL) begin
          if (req_r.func == FUNC_INSERT) begin
            raddr = free_r[AW-1:0];
            state_nxt = S_FRD;
          end else begin
            rsp_nxt.status = ST_NOTFOUND;
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rnode.key == req_r.key) begin
          if (req_r.func == FUNC_INSERT) begin
            rsp_nxt.status = ST_DUP;
            state_nxt = S_OUT;
          end else begin
            fnd_nxt = cur_r;
            fnode_nxt = rnode;
            rsp_nxt.status = ST_DELETED;
            rsp_nxt.out_key = rnode.key;
            rsp_nxt.out_nick_hi = rnode.hi;
            rsp_nxt.out_nick_lo = rnode.lo;
            if (lnk(rnode.left) != NIL && lnk(rnode.right) != NIL) begin
              sp_nxt = cur_r; ss_nxt = 1'b1;
              cur_nxt = lnk(rnode.right); steps_nxt = '0;
              state_nxt = S_SRD;
            end else begin
              plink_nxt = par_r; pside_nxt = side_r;
              pval_nxt = (lnk(rnode.left) != NIL) ? lnk(rnode.left) : lnk(rnode.right);
              freed_nxt = cur_r;
              state_nxt = S_LINK;
            end
          end
        end else if (steps_r > (AW+1)'(NODES - 1)) begin
          cur_nxt = NIL;
          state_nxt = S_RD;
        end else begin
          par_nxt = cur_r;
          side_nxt = (req_r.key < rnode.key) ? 1'b0 : 1'b1;
          cur_nxt = (req_r.key < rnode.key) ? lnk(rnode.left) : lnk(rnode.right);
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        if (lnk(rnode.left) != NIL && steps_r <= (AW+1)'(NODES - 1)) begin
          sp_nxt = cur_r; ss_nxt = 1'b0;
          cur_nxt = lnk(rnode.left);
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_SRD;
        end else begin
          snode_nxt = rnode;
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        // copy successor into found node; its old link patched here or later
        we = 1'b1;
        waddr = fnd_r[AW-1:0];
        wnode = fnode_r;
        wnode.key = snode_r.key; wnode.hi = snode_r.hi; wnode.lo = snode_r.lo;
        if (sp_r == fnd_r) wnode.right = lnk(snode_r.right);
        fnode_nxt = wnode;
        plink_nxt = (sp_r == fnd_r) ? NIL : sp_r;
        pside_nxt = ss_r;
        pval_nxt = lnk(snode_r.right);
        freed_nxt = cur_r;
        state_nxt = (sp_r == fnd_r) ? S_REL : S_LINK;
      end
      S_FRD: begin
        raddr = free_r[AW-1:0];
        state_nxt = S_LINK;
      end
      S_LINK: begin
        if (req_r.func == FUNC_INSERT) begin
          // rnode holds the free head node
          we = 1'b1;
          waddr = free_r[AW-1:0];
          wnode.key = req_r.key; wnode.hi = req_r.nick_hi; wnode.lo = req_r.nick_lo;
          wnode.left = NIL; wnode.right = NIL;
          free_nxt = lnk(rnode.right);
          plink_nxt = par_r; pside_nxt = side_r; pval_nxt = free_r;
          rsp_nxt.status = ST_INSERTED;
          rsp_nxt.slot = 4'(free_r);
          if (par_r == NIL) begin
            root_nxt = free_r;
            state_nxt = S_OUT;
          end else begin
            raddr = par_r[AW-1:0];
            state_nxt = S_LRD;
          end
        end else if (plink_r == NIL) begin
          root_nxt = pval_r;
          state_nxt = S_REL;
        end else begin
          raddr = plink_r[AW-1:0];
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        we = 1'b1;
        waddr = plink_r[AW-1:0];
        wnode = rnode;
        if (pside_r) wnode.right = pval_r; else wnode.left = pval_r;
        state_nxt = (req_r.func == FUNC_INSERT) ? S_OUT : S_REL;
      end
      S_REL: begin
        we = 1'b1;
        waddr = freed_r[AW-1:0];
        wnode = (freed_r == fnd_r) ? fnode_r : snode_r;
        wnode.left = NIL;
        wnode.right = lnk(free_r);
        free_nxt = freed_r;
        rsp_nxt.slot = 4'(freed_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          orsp_nxt = rsp_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    if (state_r == S_LINK && req_r.func == FUNC_INSERT && par_r != NIL) begin
      plink_nxt = par_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= '0;
      root_r  <= NIL;
      free_r  <= LW'(NODES - 1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      root_r  <= root_nxt;
      free_r  <= free_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; cur_r <= cur_nxt; par_r <= par_nxt; side_r <= side_nxt;
    fnd_r <= fnd_nxt; sp_r <= sp_nxt; ss_r <= ss_nxt; steps_r <= steps_nxt;
    fnode_r <= fnode_nxt; snode_r <= snode_nxt; plink_r <= plink_nxt;
    pside_r <= pside_nxt; pval_r <= pval_nxt; freed_r <= freed_nxt;
    rsp_r <= rsp_nxt; orsp_r <= orsp_nxt;
  end

  `BSTP_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_r == S_IDLE && !we,
    "ready outside idle")
  `BSTP_ASSERT_IMP(a_status_range, clk, rst_n, out_ch.valid,
    orsp_r.status == ST_INSERTED || orsp_r.status == ST_DUP || orsp_r.status == ST_FULL ||
    orsp_r.status == ST_DELETED || orsp_r.status == ST_NOTFOUND, "bad status")
  `BSTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(orsp_r), "result dropped")
  `BSTP_ASSERT_IMP(a_free_range, clk, rst_n, state_r == S_IDLE, free_r <= NIL && root_r <= NIL,
    "link out of range")
endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the node pool search tree unit against an in-bench tree predictor:
// directed inserts and deletes, pool full, duplicates and missing keys, then random
// insert/delete traffic mostly over small key sets, under several idle and stall phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import bstp_pkg::*;

  localparam int POOL = 16;
  localparam logic [4:0] NULL_SLOT = 5'd16;

  logic clk;
  logic rst_n;

  bstp_req_if req_if ();
  bstp_rsp_if rsp_if ();

  bst_insert_delete_node_pool_unit #(.NODES(POOL)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if)
  );

  logic [31:0] pool_key [POOL];
  logic [55:0] pool_hi [POOL];
  logic [55:0] pool_lo [POOL];
  logic [4:0]  pool_left [POOL];
  logic [4:0]  pool_right [POOL];
  logic [4:0]  tree_root;
  logic [4:0]  free_top;

  bstp_rsp_t expected_rsp_q [$];
  int errors;
  int beats_sent;
  int beats_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int status_hits [5];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("bst_insert_delete_node_pool_unit verification failed");
    $finish;
  end

  function automatic logic [4:0] find_key(input logic [31:0] k, output logic [4:0] par,
                                          output bit right_side);
    logic [4:0] cur;
    int steps;
    cur = tree_root;
    par = NULL_SLOT;
    right_side = 1'b0;
    steps = 0;
    while (cur < NULL_SLOT && pool_key[cur] != k && steps <= POOL) begin
      par = cur;
      right_side = (k >= pool_key[cur]);
      cur = right_side ? pool_right[cur] : pool_left[cur];
      steps++;
    end
    return (cur < NULL_SLOT && pool_key[cur] == k) ? cur : NULL_SLOT;
  endfunction

  function automatic void set_link(input logic [4:0] par, input bit right_side,
                                   input logic [4:0] v);
    if (par >= NULL_SLOT) begin
      tree_root = v;
    end else if (right_side) begin
      pool_right[par] = v;
    end else begin
      pool_left[par] = v;
    end
  endfunction

  function automatic bstp_rsp_t tree_apply(input bstp_req_t r);
    bstp_rsp_t rsp;
    logic [4:0] par, hit, s, l, rt, sp, sc;
    bit side, ss;
    int steps;
    rsp = '0;
    if (r.func == FUNC_INSERT) begin
      if (free_top >= NULL_SLOT) begin
        rsp.status = ST_FULL;
        return rsp;
      end
      hit = find_key(r.key, par, side);
      if (hit < NULL_SLOT) begin
        rsp.status = ST_DUP;
        return rsp;
      end
      s = free_top;
      free_top = pool_right[s];
      pool_key[s] = r.key;
      pool_hi[s] = r.nick_hi;
      pool_lo[s] = r.nick_lo;
      pool_left[s] = NULL_SLOT;
      pool_right[s] = NULL_SLOT;
      set_link(par, side, s);
      rsp.status = ST_INSERTED;
      rsp.slot = s[3:0];
      return rsp;
    end
    hit = find_key(r.key, par, side);
    if (hit >= NULL_SLOT) begin
      rsp.status = ST_NOTFOUND;
      return rsp;
    end
    rsp.status = ST_DELETED;
    rsp.out_key = pool_key[hit];
    rsp.out_nick_hi = pool_hi[hit];
    rsp.out_nick_lo = pool_lo[hit];
    l = pool_left[hit];
    rt = pool_right[hit];
    if (l < NULL_SLOT && rt < NULL_SLOT) begin
      sp = hit;
      sc = rt;
      ss = 1'b1;
      steps = 0;
      while (pool_left[sc] < NULL_SLOT && steps <= POOL) begin
        sp = sc;
        ss = 1'b0;
        sc = pool_left[sc];
        steps++;
      end
      pool_key[hit] = pool_key[sc];
      pool_hi[hit] = pool_hi[sc];
      pool_lo[hit] = pool_lo[sc];
      set_link(sp, ss, pool_right[sc]);
      s = sc;
    end else begin
      set_link(par, side, (l < NULL_SLOT) ? l : rt);
      s = hit;
    end
    pool_left[s] = NULL_SLOT;
    pool_right[s] = free_top;
    free_top = s;
    rsp.slot = s[3:0];
    return rsp;
  endfunction

  task automatic send_beat(input logic func, input logic [31:0] k,
                           input logic [55:0] hi, input logic [55:0] lo);
    bstp_req_t r;
    r.func = func;
    r.key = k;
    r.nick_hi = hi;
    r.nick_lo = lo;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    req_if.valid <= 1'b1;
    req_if.data <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_rsp_q.push_back(tree_apply(r));
    beats_sent++;
    req_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    bstp_rsp_t exp_rsp;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        beats_seen++;
        if (expected_rsp_q.size() == 0) begin
          errors++;
          $display("%0t unexpected beat %h", $time, rsp_if.data);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          status_hits[exp_rsp.status > 4 ? 4 : exp_rsp.status]++;
          if (rsp_if.data.status !== exp_rsp.status) begin
            errors++;
            $display("%0t status exp %0d got %0d", $time, exp_rsp.status,
                     rsp_if.data.status);
          end
          if (rsp_if.data.slot !== exp_rsp.slot) begin
            errors++;
            $display("%0t slot exp %0d got %0d", $time, exp_rsp.slot, rsp_if.data.slot);
          end
          if (rsp_if.data.out_key !== exp_rsp.out_key) begin
            errors++;
            $display("%0t key exp %h got %h", $time, exp_rsp.out_key, rsp_if.data.out_key);
          end
          if (rsp_if.data.out_nick_hi !== exp_rsp.out_nick_hi) begin
            errors++;
            $display("%0t nick_hi exp %h got %h", $time, exp_rsp.out_nick_hi,
                     rsp_if.data.out_nick_hi);
          end
          if (rsp_if.data.out_nick_lo !== exp_rsp.out_nick_lo) begin
            errors++;
            $display("%0t nick_lo exp %h got %h", $time, exp_rsp.out_nick_lo,
                     rsp_if.data.out_nick_lo);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic drain_results();
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [55:0] rand_nick();
    return 56'({$urandom, $urandom});
  endfunction

  task automatic test_directed();
    send_beat(FUNC_DELETE, 32'h0, 56'h0, 56'h0);
    send_beat(FUNC_INSERT, 32'h8000_0000, '1, '1);
    send_beat(FUNC_INSERT, 32'h8000_0000, '0, '0);
    for (int i = 0; i < 15; i++) begin
      send_beat(FUNC_INSERT, (i % 2) ? 32'hFFFF_FFFF - i : i, rand_nick(), rand_nick());
    end
    send_beat(FUNC_INSERT, 32'h1234_5678, 56'h0, 56'h0);
    send_beat(FUNC_INSERT, 32'h8000_0000, 56'h0, 56'h0);
    send_beat(FUNC_DELETE, 32'h8000_0000, 56'h0, 56'h0);
    send_beat(FUNC_DELETE, 32'h0, 56'h0, 56'h0);
    send_beat(FUNC_DELETE, 32'hFFFF_FFFE, 56'h0, 56'h0);
    send_beat(FUNC_DELETE, 32'h5555_5555, 56'h0, 56'h0);
    drain_results();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    logic [31:0] k;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(3) == 0) ? $urandom : {4'($urandom_range(15)), $urandom_range(1) ?
            28'hFFF_FFFF : 28'h0} ^ ($urandom_range(1) << 27);
      send_beat($urandom_range(99) < 55 ? FUNC_INSERT : FUNC_DELETE, k, rand_nick(),
                rand_nick());
      if (i == n / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    errors = 0;
    beats_sent = 0;
    beats_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    for (int i = 0; i < POOL; i++) begin
      pool_key[i] = '0;
      pool_hi[i] = '0;
      pool_lo[i] = '0;
      pool_left[i] = NULL_SLOT;
      pool_right[i] = (i > 0) ? 5'(i - 1) : NULL_SLOT;
    end
    tree_root = NULL_SLOT;
    free_top = 5'(POOL - 1);
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(260, 0, 0);
    test_random(260, 62, 0);
    test_random(260, 0, 62);
    test_random(260, 23, 23);
    repeat (200) @(posedge clk);
    $display("covered %0d requests, %0d results", beats_sent, beats_seen);
    $display("inserted %0d dup %0d full %0d deleted %0d missing %0d", status_hits[0],
             status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("bst_insert_delete_node_pool_unit verification clean");
    end else begin
      $display("bst_insert_delete_node_pool_unit verification failed");
    end
    $finish;
  end
endmodule
